>>> rtl/mhp_pkg.sv
// ----------------------------------------------------------------------------
// mhp_pkg
// Shared types and constants of the MOT object header parser.
// ----------------------------------------------------------------------------
package mhp_pkg;

  // header core layout
  localparam int unsigned CoreBytes   = 7;
  localparam int unsigned CoreWidth   = 8 * CoreBytes;
  localparam int unsigned IndexWidth  = 13;
  localparam int unsigned RemWidth    = 15;

  // reset value of the name parameter identifier
  localparam logic [5:0] NameIdReset = 6'd12;

  // kind of one result
  typedef enum logic [1:0] {
    KIND_CORE = 2'd0,
    KIND_CHAR = 2'd1,
    KIND_END  = 2'd2
  } result_kind_e;

  // one result item
  typedef struct packed {
    result_kind_e kind;
    logic [7:0]   name_char;
    logic [27:0]  body_size;
    logic [12:0]  header_size;
    logic [5:0]   content_type;
    logic [8:0]   content_subtype;
    logic         header_done;
  } mhp_result_t;

endpackage

>>> rtl/mhp_parse.sv
// ----------------------------------------------------------------------------
// mhp_parse
// Parser state and single-pass step logic: one header byte per transfer,
// at most one result per byte.
// ----------------------------------------------------------------------------
module mhp_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          data_byte_i,
  input  logic                start_of_header_i,
  input  logic [5:0]          name_param_id_i,
  output logic                res_valid_o,
  output mhp_pkg::mhp_result_t res_o
);
  import mhp_pkg::*;

  // parse phase codes
  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhCore = 3'd1;
  localparam logic [2:0] PhPhdr = 3'd2;
  localparam logic [2:0] PhLen1 = 3'd3;
  localparam logic [2:0] PhLen2 = 3'd4;
  localparam logic [2:0] PhData = 3'd5;
  localparam logic [2:0] PhDone = 3'd6;

  logic [2:0]            phase_q, phase_d;
  logic [IndexWidth-1:0] index_q, index_d;
  logic [RemWidth-1:0]   rem_q, rem_d;
  logic                  in_name_q, in_name_d;
  logic                  skip_q, skip_d;
  logic [6:0]            len_hi_q, len_hi_d;
  logic [CoreWidth-1:0]  core_q, core_d;

  logic                  start_len;
  logic [RemWidth-1:0]   len;
  logic                  last;
  logic                  emit_char;
  logic [IndexWidth-1:0] index_inc;
  logic [RemWidth-1:0]   rem_dec;

  // one parser step on the accepted byte
  always_comb begin
    phase_d     = phase_q;
    index_d     = index_q;
    rem_d       = rem_q;
    in_name_d   = in_name_q;
    skip_d      = skip_q;
    len_hi_d    = len_hi_q;
    core_d      = core_q;
    start_len   = 1'b0;
    len         = '0;
    last        = 1'b0;
    emit_char   = 1'b0;
    res_valid_o = 1'b0;
    res_o.kind  = KIND_END;

    // restart on the first byte of a header
    if (start_of_header_i) begin
      phase_d   = PhCore;
      index_d   = '0;
      rem_d     = '0;
      in_name_d = 1'b0;
      skip_d    = 1'b0;
      len_hi_d  = '0;
      core_d    = '0;
    end

    index_inc = index_d + IndexWidth'(1);
    rem_dec   = rem_d - RemWidth'(1);

    unique case (phase_d)
      PhCore: begin
        core_d  = {core_d[CoreWidth-9:0], data_byte_i};
        index_d = index_inc;
        if (index_inc >= IndexWidth'(CoreBytes)) begin
          last        = index_inc >= core_d[27:15];
          phase_d     = last ? PhDone : PhPhdr;
          res_valid_o = 1'b1;
          res_o.kind  = KIND_CORE;
        end
      end
      PhPhdr, PhLen1, PhLen2, PhData: begin
        unique case (phase_d)
          PhPhdr: begin
            in_name_d = 1'b0;
            unique case (data_byte_i[7:6])
              2'd0: phase_d = PhPhdr;
              2'd1: begin
                start_len = 1'b1;
                len       = RemWidth'(1);
              end
              2'd2: begin
                start_len = 1'b1;
                len       = RemWidth'(4);
              end
              default: begin
                in_name_d = (data_byte_i[5:0] == name_param_id_i);
                phase_d   = PhLen1;
              end
            endcase
          end
          PhLen1: begin
            if (data_byte_i[7]) begin
              len_hi_d = data_byte_i[6:0];
              phase_d  = PhLen2;
            end else begin
              start_len = 1'b1;
              len       = RemWidth'(data_byte_i[6:0]);
            end
          end
          PhLen2: begin
            start_len = 1'b1;
            len       = {len_hi_d, data_byte_i};
          end
          default: begin
            // data byte of a parameter
            if (in_name_d) begin
              if (skip_d) begin
                skip_d = 1'b0;
              end else begin
                emit_char = 1'b1;
              end
            end
            rem_d = rem_dec;
            if (rem_dec == '0) begin
              in_name_d = 1'b0;
              phase_d   = PhPhdr;
            end
          end
        endcase

        // length known: enter the data bytes
        if (start_len) begin
          rem_d   = len;
          skip_d  = in_name_d;
          phase_d = (len == '0) ? PhPhdr : PhData;
        end

        index_d = index_inc;
        last    = index_inc >= core_d[27:15];
        if (last) begin
          phase_d = PhDone;
        end
        res_valid_o = emit_char | last;
        res_o.kind  = emit_char ? KIND_CHAR : KIND_END;
      end
      default: begin
        // idle or past the header: byte is dropped
      end
    endcase

    res_o.name_char       = emit_char ? data_byte_i : 8'd0;
    res_o.body_size       = core_d[55:28];
    res_o.header_size     = core_d[27:15];
    res_o.content_type    = core_d[14:9];
    res_o.content_subtype = core_d[8:0];
    res_o.header_done     = last;
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      index_q   <= '0;
      rem_q     <= '0;
      in_name_q <= 1'b0;
      skip_q    <= 1'b0;
      len_hi_q  <= '0;
      core_q    <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      index_q   <= index_d;
      rem_q     <= rem_d;
      in_name_q <= in_name_d;
      skip_q    <= skip_d;
      len_hi_q  <= len_hi_d;
      core_q    <= core_d;
    end
  end

endmodule

>>> rtl/mot_header_parser.sv
// ----------------------------------------------------------------------------
// mot_header_parser
// MOT object header parser: extracts the header core fields and the name
// characters of the configured extension parameter.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  in       | sink      | in_valid_i/in_stall_o | data_byte_i, start_of_header_i
//  out      | source    | out_valid_o/out_stall_i | result_kind_o .. header_done_o
//  cfg      | sink      | cfg_valid_i/cfg_ready_o | cfg_name_param_id_i
//
// One header byte per cycle; a byte's result appears in the result register in
// the cycle after its transfer. The step is a single pass of compare and
// increment logic on small parser registers, so the rate is one byte per cycle
// unless stalled. The input stalls only while the result register is full and the
// output is stalled. Reset leaves the parser idle until a start-of-header byte.
//
module mot_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_header_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  name_char_o,
  output logic [27:0] body_size_o,
  output logic [12:0] header_size_o,
  output logic [5:0]  content_type_o,
  output logic [8:0]  content_subtype_o,
  output logic        header_done_o,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_name_param_id_i
);
  import mhp_pkg::*;

  logic        step;
  logic        res_valid;
  mhp_result_t res;
  logic [5:0]  name_id_q;
  logic        out_valid_q;
  mhp_result_t out_q;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_id_q <= NameIdReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      name_id_q <= cfg_name_param_id_i;
    end
  end

  // input transfer
  assign in_stall_o = out_valid_q & out_stall_i;
  assign step       = in_valid_i & ~in_stall_o;

  mhp_parse u_parse (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (step),
    .data_byte_i       (data_byte_i),
    .start_of_header_i (start_of_header_i),
    .name_param_id_i   (name_id_q),
    .res_valid_o       (res_valid),
    .res_o             (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= res_valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = out_q.kind;
  assign name_char_o       = out_q.name_char;
  assign body_size_o       = out_q.body_size;
  assign header_size_o     = out_q.header_size;
  assign content_type_o    = out_q.content_type;
  assign content_subtype_o = out_q.content_subtype;
  assign header_done_o     = out_q.header_done;

endmodule
